// File: rtl/next_fit_slot_allocator_assert.svh
// assertion macros used by the allocator's bitmap engine
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef NEXT_FIT_SLOT_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define NFSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nfsa_pkg.sv
// types, codes and helpers of the next-fit slot allocator
// no dependencies; used by every module of the block
`default_nettype none

package nfsa_pkg;

    // field widths and stream widths
    localparam int ACTION_W    = 2;
    localparam int SLOT_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // bitmap organization
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    localparam int POOL_SLOTS_DEF = 256;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_WAS_FREE = 2'd2
    } t_status;

    // command kind after classification in the front
    typedef enum logic [2:0] {
        K_ALLOC,
        K_RELEASE,
        K_BAD_RELEASE,
        K_CLEAR,
        K_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [SLOT_W-1:0] idx;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_REL
    } t_back_state;

    // index of the lowest set bit, zero when none is set
    function automatic logic [BIT_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// File: rtl/nfsa_front.sv
// front classifier: decodes the action and range-checks release indexes
// depends on nfsa_pkg
`default_nettype none

module nfsa_front
    import nfsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [SLOT_W-1:0]   i_slot_index,
    output t_cmd                     o_cmd
);

    logic idx_in_pool;

    // a release beyond the pool acts as a release of a free slot
    assign idx_in_pool = {24'd0, i_slot_index} < 32'(POOL_SLOTS);

    // classify the item
    always_comb begin
        o_cmd.idx = i_slot_index;
        case (i_action)
            ACT_ALLOC:   o_cmd.kind = K_ALLOC;
            ACT_RELEASE: o_cmd.kind = idx_in_pool ? K_RELEASE : K_BAD_RELEASE;
            ACT_CLEAR:   o_cmd.kind = K_CLEAR;
            default:     o_cmd.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/nfsa_fifo.sv
// short command queue between the front and the bitmap engine
// depends on nfsa_pkg
`default_nettype none

module nfsa_fifo
    import nfsa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output wire logic o_full,
    output wire logic o_empty,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_fill == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + (QPTR_W + 1)'(1);
                2'b01:   r_fill <= r_fill - (QPTR_W + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/nfsa_back.sv
// bitmap engine: word-wise next-fit scan, release and clear, result register
// depends on nfsa_pkg and next_fit_slot_allocator_assert.svh
`default_nettype none

`include "next_fit_slot_allocator_assert.svh"

module nfsa_back
    import nfsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_empty,
    input  wire t_cmd                i_q_cmd,
    output wire logic                o_q_pop,
    output wire logic                o_m_tvalid,
    input  wire logic                i_m_tready,
    output t_status                  o_status,
    output wire logic [SLOT_W-1:0]   o_slot,
    output wire logic [COUNT_W-1:0]  o_count
);

    localparam int NUM_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = WORD_AW + BIT_W;
    localparam int CNT_W     = $clog2(POOL_SLOTS + 1);
    localparam int PROBE_W   = $clog2(NUM_WORDS + 1);
    localparam int TAIL_BITS = POOL_SLOTS - WORD_BITS * (NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        WORD_BITS'((64'd1 << TAIL_BITS) - 64'd1);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
    localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(POOL_SLOTS - 1);

    // bitmap memory with one valid bit per row
    logic [WORD_BITS-1:0] r_bitmap [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_valid, n_row_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_ok;

    t_back_state          r_state, n_state;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [WORD_AW-1:0]   r_word_addr, n_word_addr;
    logic [PROBE_W-1:0]   r_probe, n_probe;
    logic [IDX_W-1:0]     r_rel_idx, n_rel_idx;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;

    logic                 q_pop;
    logic                 pool_full;
    logic [WORD_AW-1:0]   ptr_word;
    logic [BIT_W-1:0]     ptr_bit;
    logic [WORD_BITS-1:0] below_mask;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] scan_used;
    logic [WORD_BITS-1:0] scan_free;
    logic                 scan_hit;
    logic [BIT_W-1:0]     hit_bit;
    logic [IDX_W-1:0]     hit_slot;
    logic [IDX_W-1:0]     hit_next;
    logic [WORD_AW-1:0]   next_word;
    logic [IDX_W-1:0]     cmd_idx;
    logic [BIT_W-1:0]     rel_bit;
    logic                 rel_used;
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // take a command only with the result register empty
    assign q_pop     = (r_state == B_IDLE) && !i_q_empty && !r_out_valid;
    assign o_q_pop   = q_pop;
    assign pool_full = r_count == CNT_W'(POOL_SLOTS);

    // scan datapath: rows never written read as all free
    assign ptr_word   = r_ptr[IDX_W-1:BIT_W];
    assign ptr_bit    = r_ptr[BIT_W-1:0];
    assign below_mask = (WORD_BITS'(1) << ptr_bit) - WORD_BITS'(1);
    assign rd_word    = r_rd_ok ? r_rd_data : '0;
    assign scan_used  = rd_word
                      | ((r_word_addr == LAST_WORD) ? ~TAIL_MASK : '0)
                      | ((r_probe == '0) ? below_mask : '0)
                      | ((r_probe == PROBE_W'(NUM_WORDS)) ? ~below_mask : '0);
    assign scan_free  = ~scan_used;
    assign scan_hit   = |scan_free;
    assign hit_bit    = first_one(scan_free);
    assign hit_slot   = {r_word_addr, hit_bit};
    assign hit_next   = (hit_slot == LAST_SLOT) ? '0 : hit_slot + IDX_W'(1);
    assign next_word  = (r_word_addr == LAST_WORD) ? '0 : r_word_addr + WORD_AW'(1);

    // release datapath
    assign cmd_idx  = IDX_W'(i_q_cmd.idx);
    assign rel_bit  = r_rel_idx[BIT_W-1:0];
    assign rel_used = rd_word[rel_bit];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (q_pop) begin
                    if (i_q_cmd.kind == K_ALLOC && !pool_full) begin
                        n_state = B_SCAN;
                    end else if (i_q_cmd.kind == K_RELEASE) begin
                        n_state = B_REL;
                    end
                end
            end
            B_SCAN: begin
                if (scan_hit) begin
                    n_state = B_IDLE;
                end
            end
            B_REL:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // datapath controls and register updates
    always_comb begin
        n_row_valid  = r_row_valid;
        n_ptr        = r_ptr;
        n_count      = r_count;
        n_word_addr  = r_word_addr;
        n_probe      = r_probe;
        n_rel_idx    = r_rel_idx;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_count  = r_out_count;
        rd_en        = 1'b0;
        rd_addr      = ptr_word;
        wr_en        = 1'b0;
        wr_addr      = r_word_addr;
        wr_data      = rd_word;
        case (r_state)
            B_IDLE: begin
                if (q_pop) begin
                    case (i_q_cmd.kind)
                        K_ALLOC: begin
                            if (pool_full) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_FULL;
                                n_out_slot   = '0;
                                n_out_count  = COUNT_W'(r_count);
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = ptr_word;
                                n_word_addr = ptr_word;
                                n_probe     = '0;
                            end
                        end
                        K_RELEASE: begin
                            rd_en     = 1'b1;
                            rd_addr   = cmd_idx[IDX_W-1:BIT_W];
                            n_rel_idx = cmd_idx;
                        end
                        K_BAD_RELEASE: begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_WAS_FREE;
                            n_out_slot   = '0;
                            n_out_count  = COUNT_W'(r_count);
                        end
                        K_CLEAR: begin
                            n_row_valid  = '0;
                            n_ptr        = '0;
                            n_count      = '0;
                            n_out_valid  = 1'b1;
                            n_out_status = ST_DONE;
                            n_out_slot   = '0;
                            n_out_count  = '0;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_DONE;
                            n_out_slot   = '0;
                            n_out_count  = COUNT_W'(r_count);
                        end
                    endcase
                end
            end
            B_SCAN: begin
                if (scan_hit) begin
                    wr_en                    = 1'b1;
                    wr_addr                  = r_word_addr;
                    wr_data                  = rd_word | (WORD_BITS'(1) << hit_bit);
                    n_row_valid[r_word_addr] = 1'b1;
                    n_ptr                    = hit_next;
                    n_count                  = r_count + CNT_W'(1);
                    n_out_valid              = 1'b1;
                    n_out_status             = ST_DONE;
                    n_out_slot               = SLOT_W'(hit_slot);
                    n_out_count              = COUNT_W'(r_count + CNT_W'(1));
                end else begin
                    rd_en       = 1'b1;
                    rd_addr     = next_word;
                    n_word_addr = next_word;
                    n_probe     = r_probe + PROBE_W'(1);
                end
            end
            B_REL: begin
                n_out_valid = 1'b1;
                n_out_slot  = '0;
                if (rel_used) begin
                    wr_en                                  = 1'b1;
                    wr_addr                                = r_rel_idx[IDX_W-1:BIT_W];
                    wr_data                                = rd_word & ~(WORD_BITS'(1) << rel_bit);
                    n_row_valid[r_rel_idx[IDX_W-1:BIT_W]]  = 1'b1;
                    n_count                                = r_count - CNT_W'(1);
                    n_out_status                           = ST_DONE;
                    n_out_count                            = COUNT_W'(r_count - CNT_W'(1));
                end else begin
                    n_out_status = ST_WAS_FREE;
                    n_out_count  = COUNT_W'(r_count);
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_m_tready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_row_valid <= '0;
            r_ptr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word_addr  <= n_word_addr;
        r_probe      <= n_probe;
        r_rel_idx    <= n_rel_idx;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_count  <= n_out_count;
    end

    // bitmap memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bitmap[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_bitmap[rd_addr];
            r_rd_ok   <= r_row_valid[rd_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_status;
    assign o_slot     = r_out_slot;
    assign o_count    = r_out_count;

    // checks
    `NFSA_ASSERT_NOW(a_busy_out_empty, r_state != B_IDLE, !r_out_valid, "result pending while busy")
    `NFSA_ASSERT_NOW(a_scan_one_lap, r_state == B_SCAN, r_probe <= PROBE_W'(NUM_WORDS), "scan overran one lap")
    `NFSA_ASSERT_NEXT(a_alloc_count, r_state == B_SCAN && scan_hit, r_count == $past(r_count) + CNT_W'(1), "count not raised")
    `NFSA_ASSERT_NEXT(a_clear_state, q_pop && i_q_cmd.kind == K_CLEAR, r_count == '0 && r_ptr == '0 && r_row_valid == '0 && r_out_valid, "clear incomplete")

endmodule

`default_nettype wire

// File: rtl/next_fit_slot_allocator.sv
// top level of the next-fit slot allocator: front classifier, queue, bitmap engine
// depends on nfsa_pkg, nfsa_front, nfsa_fifo, nfsa_back
//
//  port group   dir  tdata fields (lsb first)                       handshake
//  s (request)  in   action[1:0] slot_index[9:2], zero pad to 16     i_s_tvalid/o_s_tready
//  m (result)   out  status[1:0] granted_slot[9:2] live_count[18:10] o_m_tvalid/i_m_tready
//
// allocate reads one bitmap word per cycle from the bitmap memory, scanning at most one lap
// of the words back to the start word; a full pool answers without a scan
// release reads the word, then writes it back; clear and no-op need no bitmap access
// reset is synchronous and needs no clearing pass: per-row valid bits mark rows as free
// requests enter a 4-entry queue and are accepted while a result waits downstream
`default_nettype none

module next_fit_slot_allocator
    import nfsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output wire logic                   o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // action, slot_index
    output wire logic                   o_m_tvalid,
    input  wire logic                   i_m_tready,
    output wire logic [OUT_TDATA_W-1:0] o_m_tdata    // status, granted_slot, live_count
);

    t_cmd               front_cmd;
    t_cmd               q_cmd;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    t_status            res_status;
    logic [SLOT_W-1:0]  res_slot;
    logic [COUNT_W-1:0] res_count;

    // request decode
    nfsa_front #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_front (
        .i_action     (i_s_tdata[ACTION_W-1:0]),
        .i_slot_index (i_s_tdata[ACTION_W+SLOT_W-1:ACTION_W]),
        .o_cmd        (front_cmd)
    );

    // request queue
    nfsa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    assign o_s_tready = !q_full;

    // bitmap engine
    nfsa_back #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_status   (res_status),
        .o_slot     (res_slot),
        .o_count    (res_count)
    );

    // result packing
    assign o_m_tdata = {(OUT_TDATA_W - STATUS_W - SLOT_W - COUNT_W)'(0),
                        res_count, res_slot, res_status};

endmodule

`default_nettype wire

// File: tb/sv/next_fit_slot_allocator_test.sv
// self-checking bench for the next-fit slot allocator: table of directed items, then random
// sequences, with a local occupancy model predicting the results not given in the table; needs nfsa_pkg and the rtl
`default_nettype none

module next_fit_slot_allocator_test
    import nfsa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL         = POOL_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1730;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 30;
    localparam int PAD_W        = IN_TDATA_W - ACTION_W - SLOT_W;
    localparam int N_DIRECTED   = 20;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } t_alloc_result;

    // one directed item; typed rows carry the result to expect
    typedef struct packed {
        t_action             act;
        logic [SLOT_W-1:0]   idx;
        logic                typed;
        t_status             st;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  cnt;
    } t_directed_row;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;    // action, slot_index
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // status, granted_slot, live_count

    // occupancy model of the pool
    bit  slot_busy [POOL];
    int  next_probe = 0;
    int  busy_total = 0;

    t_alloc_result pending_results [$];
    int            mismatch_count = 0;
    int            sent_count     = 0;
    int            cycle_count    = 0;
    bit            calm           = 1'b0;

    t_directed_row steps [0:N_DIRECTED-1] = '{
        '{ACT_RELEASE, 8'h00, 1'b1, ST_WAS_FREE, 8'd0, 9'd0},
        '{ACT_ALLOC,   8'hff, 1'b1, ST_DONE,     8'd0, 9'd1},
        '{ACT_ALLOC,   8'h00, 1'b1, ST_DONE,     8'd1, 9'd2},
        '{ACT_ALLOC,   8'haa, 1'b1, ST_DONE,     8'd2, 9'd3},
        '{ACT_RELEASE, 8'hff, 1'b1, ST_WAS_FREE, 8'd0, 9'd3},
        '{ACT_RELEASE, 8'h01, 1'b1, ST_DONE,     8'd0, 9'd2},
        '{ACT_RELEASE, 8'h01, 1'b1, ST_WAS_FREE, 8'd0, 9'd2},
        '{ACT_ALLOC,   8'h55, 1'b1, ST_DONE,     8'd3, 9'd3},
        '{ACT_NOP,     8'hff, 1'b1, ST_DONE,     8'd0, 9'd3},
        '{ACT_NOP,     8'h00, 1'b1, ST_DONE,     8'd0, 9'd3},
        '{ACT_CLEAR,   8'h55, 1'b1, ST_DONE,     8'd0, 9'd0},
        '{ACT_ALLOC,   8'h00, 1'b1, ST_DONE,     8'd0, 9'd1},
        '{ACT_RELEASE, 8'h00, 1'b1, ST_DONE,     8'd0, 9'd0},
        '{ACT_ALLOC,   8'hff, 1'b0, ST_DONE,     8'd0, 9'd0},
        '{ACT_RELEASE, 8'h80, 1'b0, ST_DONE,     8'd0, 9'd0},
        '{ACT_RELEASE, 8'h01, 1'b0, ST_DONE,     8'd0, 9'd0},
        '{ACT_CLEAR,   8'hff, 1'b1, ST_DONE,     8'd0, 9'd0},
        '{ACT_RELEASE, 8'h80, 1'b1, ST_WAS_FREE, 8'd0, 9'd0},
        '{ACT_ALLOC,   8'h7f, 1'b1, ST_DONE,     8'd0, 9'd1},
        '{ACT_CLEAR,   8'h00, 1'b1, ST_DONE,     8'd0, 9'd0}
    };

    next_fit_slot_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // apply one item to the occupancy model and return its result
    function automatic t_alloc_result pool_outcome(input t_action act,
                                                   input logic [SLOT_W-1:0] idx);
        t_alloc_result r;
        int            s;
        bit            found;
        r.status = ST_DONE;
        r.slot   = '0;
        found    = 1'b0;
        case (act)
            ACT_ALLOC: begin
                for (int i = 0; i < POOL; i++) begin
                    s = (next_probe + i) % POOL;
                    if (!found && !slot_busy[s]) begin
                        found        = 1'b1;
                        slot_busy[s] = 1'b1;
                        busy_total++;
                        next_probe   = (s + 1) % POOL;
                        r.slot       = SLOT_W'(s);
                    end
                end
                if (!found) begin
                    r.status = ST_FULL;
                end
            end
            ACT_RELEASE: begin
                if (int'(idx) < POOL && slot_busy[idx]) begin
                    slot_busy[idx] = 1'b0;
                    if (busy_total > 0) begin
                        busy_total--;
                    end
                end else begin
                    r.status = ST_WAS_FREE;
                end
            end
            ACT_CLEAR: begin
                foreach (slot_busy[i]) slot_busy[i] = 1'b0;
                next_probe = 0;
                busy_total = 0;
            end
            default: ;
        endcase
        r.count = COUNT_W'(busy_total);
        return r;
    endfunction

    // some slot now in use, found from a random start; random when the pool is empty
    function automatic logic [SLOT_W-1:0] pick_live_slot();
        int start;
        int s;
        start = $urandom_range(0, POOL - 1);
        for (int i = 0; i < POOL; i++) begin
            s = (start + i) % POOL;
            if (slot_busy[s]) begin
                return SLOT_W'(s);
            end
        end
        return SLOT_W'(start);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // offer one item, with random gaps unless calm is set, and record its expected result once taken
    task automatic send_item(input t_action act, input logic [SLOT_W-1:0] idx,
                             input bit typed, input t_alloc_result typed_res);
        t_alloc_result res;
        while (!calm && $urandom_range(0, 99) < 19) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{PAD_W{1'b0}}, idx, act};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        res = pool_outcome(act, idx);
        pending_results.push_back(typed ? typed_res : res);
        sent_count++;
    endtask

    task automatic send_random(input t_action act, input logic [SLOT_W-1:0] idx);
        send_item(act, idx, 1'b0, '0);
    endtask

    // hold the sender until every expected result is back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(0, 99) >= 19);
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", int'(o_m_tdata[1:0]), -1);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", int'(o_m_tdata[1:0]), int'(want.status));
                if (o_m_tdata[9:2] !== want.slot)
                    report_mismatch("granted_slot", int'(o_m_tdata[9:2]), int'(want.slot));
                if (o_m_tdata[18:10] !== want.count)
                    report_mismatch("live_count", int'(o_m_tdata[18:10]), int'(want.count));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int seg;
        int mode;
        int bias;
        int r;
        seg = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (steps[k]) begin
            send_item(steps[k].act, steps[k].idx, steps[k].typed,
                      '{steps[k].st, steps[k].slot, steps[k].cnt});
        end

        // random sequences
        while (sent_count < N_DIRECTED + RANDOM_ITEMS) begin
            calm <= (sent_count >= 700 && sent_count < 1000);
            mode = (seg == 0) ? 0 : $urandom_range(0, 99);
            if (seg == 12) begin
                wait_drained();
            end
            if (mode < 4) begin
                // fill to full, then knock on the full pool
                while (busy_total < POOL) begin
                    send_random(ACT_ALLOC, SLOT_W'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(1, 3)) begin
                    send_random(ACT_ALLOC, SLOT_W'($urandom_range(0, 255)));
                end
            end else if (mode < 10) begin
                send_random(ACT_CLEAR, SLOT_W'($urandom_range(0, 255)));
            end else if (mode < 20) begin
                // noise: any code, any index
                repeat (8) begin
                    send_random(t_action'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 255)));
                end
            end else begin
                // allocate and release mix with a per-run bias
                bias = $urandom_range(30, 80);
                repeat ($urandom_range(16, 40)) begin
                    r = $urandom_range(0, 99);
                    if (r < bias) begin
                        send_random(ACT_ALLOC, SLOT_W'($urandom_range(0, 255)));
                    end else if (r < bias + (100 - bias) * 3 / 4) begin
                        send_random(ACT_RELEASE, pick_live_slot());
                    end else begin
                        send_random(ACT_RELEASE, SLOT_W'($urandom_range(0, 255)));
                    end
                end
            end
            seg++;
        end

        // drain and let the block settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results still pending", pending_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
